// ----- rtl/eba_pkg.sv -----
// Shared types and constants for the eight-bit ALU with BCD flags.
package eba_pkg;

	typedef enum logic [3:0] {
		OP_OR   = 4'd0,
		OP_AND  = 4'd1,
		OP_EOR  = 4'd2,
		OP_ADC  = 4'd3,
		OP_SBC  = 4'd4,
		OP_CMP  = 4'd5,
		OP_BIT  = 4'd6,
		OP_ASL  = 4'd7,
		OP_LSR  = 4'd8,
		OP_ROL  = 4'd9,
		OP_ROR  = 4'd10,
		OP_INC  = 4'd11,
		OP_DEC  = 4'd12,
		OP_LOAD = 4'd13
	} op_t;

	localparam logic [3:0] BCD_DIGIT_MAX = 4'd9;
	localparam logic [4:0] BCD_HIGH_MAX  = 5'd9;
	localparam logic [9:0] BCD_ADJ_LO    = 10'h006;
	localparam logic [9:0] BCD_ADJ_HI    = 10'h060;
	localparam logic [5:0] BCD_SUB_ADJ   = 6'd6;

	typedef struct packed {
		op_t        op;
		logic [7:0] reg_value;
		logic [7:0] operand;
		logic       carry_in;
		logic       overflow_in;
		logic       decimal_mode;
	} alu_req_t;

	typedef struct packed {
		logic [7:0] result;
		logic       carry;
		logic       zero;
		logic       negative;
		logic       overflow;
	} alu_rsp_t;

endpackage

// ----- rtl/eba_core.sv -----
// Combinational ALU datapath: logic, binary and BCD arithmetic, compare, shifts.
module eba_core (
	input  eba_pkg::alu_req_t req,
	output eba_pkg::alu_rsp_t rsp
);

	logic [7:0] a;
	logic [7:0] m;
	logic       c;
	logic [8:0] bin_sum;
	logic [8:0] bin_diff;
	logic [8:0] cmp_diff;
	logic [9:0] dec_t1;
	logic [9:0] dec_t2;
	logic [5:0] lo0;
	logic [5:0] hi0;
	logic [5:0] lo1;
	logic [5:0] hi1;
	logic [5:0] hi2;
	logic [7:0] res;
	logic [7:0] flagval;
	logic       n;
	logic       cy;
	logic       ov;

	assign a = req.reg_value;
	assign m = req.operand;
	assign c = req.carry_in;

	assign bin_sum  = {1'b0, a} + {1'b0, m} + {8'b0, c};
	assign bin_diff = {1'b0, a} - {1'b0, m} - {8'b0, ~c};
	assign cmp_diff = {1'b0, a} - {1'b0, m};

	assign dec_t1 = (bin_sum[3:0] > eba_pkg::BCD_DIGIT_MAX) ?
		({1'b0, bin_sum} + eba_pkg::BCD_ADJ_LO) : {1'b0, bin_sum};
	assign dec_t2 = (dec_t1[8:4] > eba_pkg::BCD_HIGH_MAX) ?
		(dec_t1 + eba_pkg::BCD_ADJ_HI) : dec_t1;

	assign lo0 = {2'b0, a[3:0]} - {2'b0, m[3:0]} - {5'b0, ~c};
	assign hi0 = {2'b0, a[7:4]} - {2'b0, m[7:4]};
	assign lo1 = lo0[5] ? (lo0 - eba_pkg::BCD_SUB_ADJ) : lo0;
	assign hi1 = lo0[5] ? (hi0 - 6'd1) : hi0;
	assign hi2 = hi1[5] ? (hi1 - eba_pkg::BCD_SUB_ADJ) : hi1;

	always_comb begin
		res     = a;
		cy      = c;
		ov      = req.overflow_in;
		flagval = a;
		n       = a[7];
		case (req.op)
			eba_pkg::OP_OR: begin
				res = a | m;
			end
			eba_pkg::OP_AND: begin
				res = a & m;
			end
			eba_pkg::OP_EOR: begin
				res = a ^ m;
			end
			eba_pkg::OP_ADC: begin
				ov = ~(a[7] ^ m[7]) & (a[7] ^ bin_sum[7]);
				if (req.decimal_mode) begin
					res = dec_t2[7:0];
					cy  = |dec_t2[9:8];
				end else begin
					res = bin_sum[7:0];
					cy  = bin_sum[8];
				end
			end
			eba_pkg::OP_SBC: begin
				ov = (a[7] ^ m[7]) & (a[7] ^ bin_diff[7]);
				cy = ~bin_diff[8];
				if (req.decimal_mode) begin
					res = {hi2[3:0], lo1[3:0]};
				end else begin
					res = bin_diff[7:0];
				end
			end
			eba_pkg::OP_ASL: begin
				res = {m[6:0], 1'b0};
				cy  = m[7];
			end
			eba_pkg::OP_LSR: begin
				res = {1'b0, m[7:1]};
				cy  = m[0];
			end
			eba_pkg::OP_ROL: begin
				res = {m[6:0], c};
				cy  = m[7];
			end
			eba_pkg::OP_ROR: begin
				res = {c, m[7:1]};
				cy  = m[0];
			end
			eba_pkg::OP_INC: begin
				res = m + 8'd1;
			end
			eba_pkg::OP_DEC: begin
				res = m - 8'd1;
			end
			eba_pkg::OP_LOAD: begin
				res = m;
			end
			default: begin
				res = a;
			end
		endcase
		flagval = res;
		n       = res[7];
		case (req.op)
			eba_pkg::OP_CMP: begin
				flagval = cmp_diff[7:0];
				n       = cmp_diff[7];
				cy      = ~cmp_diff[8];
			end
			eba_pkg::OP_BIT: begin
				flagval = a & m;
				n       = m[7];
				ov      = m[6];
			end
			default: begin
				flagval = res;
			end
		endcase
	end

	assign rsp.result   = res;
	assign rsp.carry    = cy;
	assign rsp.zero     = (flagval == 8'd0);
	assign rsp.negative = n;
	assign rsp.overflow = ov;

endmodule

// ----- rtl/eight_bit_alu_with_bcd_flags.sv -----
// Top level: input register, ALU datapath and result register with valid/stall flow control.
//
// Usage: the input channel carries one operation word (op, reg_value, operand,
// carry_in, overflow_in, decimal_mode), taken at a rising edge of clk with in_valid
// high and in_stall low. The result channel carries one word (result and the four
// flags) for each input word, in order, taken when out_valid is high and out_stall low.
// Each word passes from the input register through the combinational ALU datapath
// into the result register, which drives out_valid, result and the four flags.
// Throughput is one word per cycle as long as the receiver does not stall.
// When the receiver stalls, the result register holds its word, the input register
// fills, and in_stall rises only once both registers hold a word.
// An asynchronous reset on arst_n empties both registers; out_valid is low after reset.
module eight_bit_alu_with_bcd_flags (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] op,
	input  logic [7:0] reg_value,
	input  logic [7:0] operand,
	input  logic       carry_in,
	input  logic       overflow_in,
	input  logic       decimal_mode,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] result,
	output logic       carry_out,
	output logic       zero_flag,
	output logic       negative_flag,
	output logic       overflow_out
);

	eba_pkg::alu_req_t req_s1;
	eba_pkg::alu_rsp_t rsp_comb;
	eba_pkg::alu_rsp_t rsp_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              adv_s2;
	logic              take_s1;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s2;
	assign take_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			req_s1.op           <= eba_pkg::op_t'(op);
			req_s1.reg_value    <= reg_value;
			req_s1.operand      <= operand;
			req_s1.carry_in     <= carry_in;
			req_s1.overflow_in  <= overflow_in;
			req_s1.decimal_mode <= decimal_mode;
		end
		if (adv_s2 && valid_s1) begin
			rsp_s2 <= rsp_comb;
		end
	end

	eba_core u_core (
		.req (req_s1),
		.rsp (rsp_comb)
	);

	assign out_valid     = valid_s2;
	assign result        = rsp_s2.result;
	assign carry_out     = rsp_s2.carry;
	assign zero_flag     = rsp_s2.zero;
	assign negative_flag = rsp_s2.negative;
	assign overflow_out  = rsp_s2.overflow;

	a_s1_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> out_valid)
		else $error("word in the input register did not reach the result register");

	a_cmp_keeps_reg: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 && (req_s1.op == eba_pkg::OP_CMP)
		|=> result == $past(req_s1.reg_value))
		else $error("compare result differs from the register value");

	a_lsr_clears_neg: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 && (req_s1.op == eba_pkg::OP_LSR) |=> !negative_flag)
		else $error("logical shift right left the negative flag set");

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled while a register was free");

endmodule
